### hdl/terrain_footprint_corner_sampler_defines.svh
// Assertion helpers shared by the checker.
`ifndef TERRAIN_FOOTPRINT_CORNER_SAMPLER_DEFINES_SVH
`define TERRAIN_FOOTPRINT_CORNER_SAMPLER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TFCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define TFCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tfcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfcs_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 128;
  localparam int MAX_LAYERS = 4;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int LAYER_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int ADDR_W  = COL_W + ROW_W + LAYER_W;
  localparam int DEPTH   = 2 ** ADDR_W;

  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] GRID_WIDTH_RST  = 8'd128;
  localparam logic [7:0] GRID_DEPTH_RST  = 8'd128;
  localparam logic [2:0] LAYER_COUNT_RST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_DEPTH  = 2'd1,
    CFG_LAYER_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CORNER_SW = 2'd0,
    CORNER_SE = 2'd1,
    CORNER_NE = 2'd2,
    CORNER_NW = 2'd3
  } corner_e;

  typedef struct packed {
    op_e                        operation;
    logic [6:0]                 col;
    logic [6:0]                 row;
    logic [1:0]                 layer;
    logic signed [HEIGHT_W-1:0] write_value;
    logic [3:0]                 footprint_width;
    logic [3:0]                 footprint_depth;
  } req_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] corner_sw;
    logic signed [HEIGHT_W-1:0] corner_se;
    logic signed [HEIGHT_W-1:0] corner_ne;
    logic signed [HEIGHT_W-1:0] corner_nw;
    logic signed [HEIGHT_W-1:0] mean_height;
    logic                       bad_coordinate;
  } rsp_t;

  typedef struct packed {
    logic    clear_en;
    logic    capture;
    logic    store;
    corner_e rd_corner;
    logic    latch_sw;
    logic    latch_se;
    logic    latch_ne;
    logic    finish_zero;
    logic    finish_query;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic bad;
    logic is_write;
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/terrain_footprint_corner_sampler.sv
// Terrain height store with footprint corner queries. After reset the block sweeps its
// 65536-entry height memory to zero, one entry per cycle, and holds busy high while it
// does so; configuration writes are taken throughout, with cfg_ready_o always high.
// A request is taken when start is high and busy is low. A write, or any request with a
// coordinate outside the grid, is finished in the check state after acceptance; a query
// reads its four corners one after another through the single port of the height memory
// and is finished in a last state after the reads. A result is shown for exactly one
// cycle with result_valid_o and cannot be held off, and busy falls in that same cycle, so
// a new request can be taken while the result is on the ports.
`timescale 1ns / 1ps
`default_nettype none

module terrain_footprint_corner_sampler import tfcs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire req_t                  req_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output rsp_t                       rsp_o,
  output logic                       result_valid_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tfcs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .status_i(status),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  tfcs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .rsp_o         (rsp_o),
    .result_valid_o(result_valid_o)
  );

  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

### hdl/tfcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tfcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/tfcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tfcs_ctrl import tfcs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o,
  output logic            busy
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_RD_SE = 7'b0001000,
    ST_RD_NE = 7'b0010000,
    ST_RD_NW = 7'b0100000,
    ST_LAST  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_corner = CORNER_SW;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status_i.bad) begin
          cmd_o.finish_zero = 1'b1;
          state_d = ST_IDLE;
        end else if (status_i.is_write) begin
          cmd_o.store       = 1'b1;
          cmd_o.finish_zero = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.rd_corner = CORNER_SW;
          state_d = ST_RD_SE;
        end
      end
      ST_RD_SE: begin
        cmd_o.rd_corner = CORNER_SE;
        cmd_o.latch_sw  = 1'b1;
        state_d = ST_RD_NE;
      end
      ST_RD_NE: begin
        cmd_o.rd_corner = CORNER_NE;
        cmd_o.latch_se  = 1'b1;
        state_d = ST_RD_NW;
      end
      ST_RD_NW: begin
        cmd_o.rd_corner = CORNER_NW;
        cmd_o.latch_ne  = 1'b1;
        state_d = ST_LAST;
      end
      ST_LAST: begin
        cmd_o.finish_query = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### hdl/tfcs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tfcs_datapath import tfcs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire req_t                  req_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o,
  output rsp_t                       rsp_o,
  output logic                       result_valid_o
);

  logic [7:0]        grid_width_q, grid_depth_q;
  logic [2:0]        layer_count_q;
  req_t              req_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [HEIGHT_W-1:0] sw_q, se_q, ne_q;
  rsp_t              rsp_q;
  logic              valid_q;

  logic [7:0] eff_w, eff_d;
  logic [2:0] eff_l;
  logic       bad;
  logic [7:0] col_ext, row_ext, col_sum, row_sum;
  logic [3:0] fw_lo, fw_hi, fd_lo, fd_hi;
  logic       col_fit, row_fit;
  logic [7:0] sc, ec, sr, er, col_sel, row_sel;
  logic       se_in, ne_in, nw_in;
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  logic [HEIGHT_W-1:0] mem_wdata, mem_rdata;
  logic [HEIGHT_W-1:0] se_val, ne_val, nw_val;
  logic [HEIGHT_W+1:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_depth_q  <= GRID_DEPTH_RST;
      layer_count_q <= LAYER_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        CFG_GRID_DEPTH:  grid_depth_q  <= cfg_data_i;
        CFG_LAYER_COUNT: layer_count_q <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_comb begin
    eff_w = (grid_width_q > 8'(MAX_COLS)) ? 8'(MAX_COLS) : grid_width_q;
    eff_d = (grid_depth_q > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : grid_depth_q;
    eff_l = (layer_count_q > 3'(MAX_LAYERS)) ? 3'(MAX_LAYERS) : layer_count_q;

    col_ext = {1'b0, req_q.col};
    row_ext = {1'b0, req_q.row};
    bad = !((col_ext < eff_w) && (row_ext < eff_d) && ({1'b0, req_q.layer} < eff_l));

    fw_lo = req_q.footprint_width >> 1;
    fw_hi = 4'(({1'b0, req_q.footprint_width} + 5'd1) >> 1);
    fd_lo = req_q.footprint_depth >> 1;
    fd_hi = 4'(({1'b0, req_q.footprint_depth} + 5'd1) >> 1);

    col_sum = col_ext + {4'b0, req_q.footprint_width};
    row_sum = row_ext + {4'b0, req_q.footprint_depth};
    col_fit = col_sum < eff_w;
    row_fit = row_sum < eff_d;

    sc = col_fit ? col_ext + {4'b0, fw_lo} : col_ext;
    ec = col_fit ? col_ext + {4'b0, fw_hi} : col_ext + 8'd1;
    sr = row_fit ? row_ext + {4'b0, fd_lo} : row_ext;
    er = row_fit ? row_ext + {4'b0, fd_hi} : row_ext + 8'd1;

    se_in = ec < eff_w;
    nw_in = er < eff_d;
    ne_in = se_in && nw_in;
  end

  always_comb begin
    unique case (cmd_i.rd_corner)
      CORNER_SW: begin
        col_sel = sc;
        row_sel = sr;
      end
      CORNER_SE: begin
        col_sel = ec;
        row_sel = sr;
      end
      CORNER_NE: begin
        col_sel = ec;
        row_sel = er;
      end
      CORNER_NW: begin
        col_sel = sc;
        row_sel = er;
      end
      default: begin
        col_sel = sc;
        row_sel = sr;
      end
    endcase
  end

  always_comb begin
    if (cmd_i.clear_en) begin
      mem_addr  = clr_cnt_q;
      mem_wdata = '0;
    end else if (cmd_i.store) begin
      mem_addr  = {req_q.layer[LAYER_W-1:0], req_q.row[ROW_W-1:0], req_q.col[COL_W-1:0]};
      mem_wdata = req_q.write_value;
    end else begin
      mem_addr  = {req_q.layer[LAYER_W-1:0], row_sel[ROW_W-1:0], col_sel[COL_W-1:0]};
      mem_wdata = req_q.write_value;
    end
    mem_we = cmd_i.clear_en || cmd_i.store;
  end

  tfcs_ram #(
    .WIDTH(HEIGHT_W),
    .DEPTH(DEPTH)
  ) u_height_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign se_val = se_in ? mem_rdata : sw_q;
  assign ne_val = ne_in ? mem_rdata : sw_q;
  assign nw_val = nw_in ? mem_rdata : sw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_sw) begin
      sw_q <= mem_rdata;
    end
    if (cmd_i.latch_se) begin
      se_q <= se_val;
    end
    if (cmd_i.latch_ne) begin
      ne_q <= ne_val;
    end
  end

  assign sum = {{2{sw_q[HEIGHT_W-1]}}, sw_q} + {{2{se_q[HEIGHT_W-1]}}, se_q}
             + {{2{ne_q[HEIGHT_W-1]}}, ne_q} + {{2{nw_val[HEIGHT_W-1]}}, nw_val};

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_zero) begin
      rsp_q.corner_sw      <= '0;
      rsp_q.corner_se      <= '0;
      rsp_q.corner_ne      <= '0;
      rsp_q.corner_nw      <= '0;
      rsp_q.mean_height    <= '0;
      rsp_q.bad_coordinate <= bad;
    end else if (cmd_i.finish_query) begin
      rsp_q.corner_sw      <= sw_q;
      rsp_q.corner_se      <= se_q;
      rsp_q.corner_ne      <= ne_q;
      rsp_q.corner_nw      <= nw_val;
      rsp_q.mean_height    <= sum[HEIGHT_W+1:2];
      rsp_q.bad_coordinate <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish_zero || cmd_i.finish_query;
    end
  end

  assign status_o.clear_done = &clr_cnt_q;
  assign status_o.bad        = bad;
  assign status_o.is_write   = (req_q.operation == OP_WRITE);
  assign rsp_o               = rsp_q;
  assign result_valid_o      = valid_q;

endmodule

`default_nettype wire

### hdl/tfcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "terrain_footprint_corner_sampler_defines.svh"

module tfcs_checker import tfcs_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire req_t                  req_i,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input wire rsp_t                  rsp_o,
  input wire logic                  result_valid_o
);

  `TFCS_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "request accepted but busy low")
  `TFCS_ASSERT(a_result_after_work, result_valid_o |-> $past(busy), "result without work")
  `TFCS_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o, "result strobe too long")
  `TFCS_ASSERT(a_bad_zero,
               (result_valid_o && rsp_o.bad_coordinate)
               |-> (rsp_o.corner_sw == '0 && rsp_o.mean_height == '0),
               "flagged result not zero")

endmodule

bind terrain_footprint_corner_sampler tfcs_checker u_tfcs_checker (.*);

`default_nettype wire
